/* rtl/core/mul_div_64_saturating_defines.svh */
`ifndef MUL_DIV_64_SATURATING_DEFINES_SVH
`define MUL_DIV_64_SATURATING_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low
`define MDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low
`define MDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/mds_pkg.sv */
package mds_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned CNT_W  = 6;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_CHK  = 5'b00100,
		S_DIV  = 5'b01000,
		S_WB   = 5'b10000
	} state_t;

endpackage

/* rtl/core/mds_if.sv */
interface mds_req_if;
	import mds_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] multiplicand;
	logic [DATA_W-1:0] multiplier;
	logic [DATA_W-1:0] denominator;

	modport source (output valid, output multiplicand, output multiplier,
		output denominator, input ready);
	modport sink (input valid, input multiplicand, input multiplier,
		input denominator, output ready);
endinterface

interface mds_rsp_if;
	import mds_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] quotient;
	logic [1:0]        status;

	modport source (output valid, output quotient, output status, input ready);
	modport sink (input valid, input quotient, input status, output ready);
endinterface

/* rtl/core/mul_div_64_saturating.sv */
// Unsigned (multiplicand * multiplier) / denominator at 64 bits, floor of the
// 128-bit product over the divisor. A zero divisor gives all ones with status 2;
// a quotient that would not fit in 64 bits gives all ones with status 1. One item
// is in flight at a time: the transfer is taken, a bit-serial shift-add multiply
// runs, one step checks the upper half, the restoring divider retires one
// quotient bit per cycle and a last step loads the output register; a saturated
// item skips the divider. The multiplier uses a 64-bit adder and the divider a
// 65-bit subtractor. The result register frees the core, but the core waits in
// its last step while an earlier result is untaken.
`include "mul_div_64_saturating_defines.svh"

module mul_div_64_saturating (
	input  logic       clk,
	input  logic       arst_n,
	mds_req_if.sink    req,
	mds_rsp_if.source  rsp
);
	import mds_pkg::*;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_W-1:0]     mcand_q;
	logic [DATA_W-1:0]     den_q;
	logic [2*DATA_W-1:0]   prod_q;
	logic [DATA_W-1:0]     rem_q;
	status_t               res_st_q;

	logic                  out_valid_q;
	logic [DATA_W-1:0]     out_quot_q;
	status_t               out_st_q;

	logic [DATA_W:0]       mul_sum;
	logic [DATA_W:0]       div_shift;
	logic [DATA_W+1:0]     div_diff;
	logic                  div_ge;
	logic                  last_step;
	logic                  out_free;

	assign last_step = (cnt_q == {CNT_W{1'b1}});
	assign out_free  = !out_valid_q || rsp.ready;

	// add the multiplicand into the upper half when the multiplier bit is set
	assign mul_sum = {1'b0, prod_q[2*DATA_W-1:DATA_W]}
		+ (prod_q[0] ? {1'b0, mcand_q} : {(DATA_W+1){1'b0}});

	// remainder shifted left with the next dividend bit; rem < den so it fits 65 bits
	assign div_shift = {rem_q, prod_q[DATA_W-1]};
	assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
	assign div_ge    = !div_diff[DATA_W+1];

	assign req.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			res_st_q <= ST_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_MUL;
						cnt_q   <= '0;
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						state_q <= S_CHK;
				end
				S_CHK: begin
					cnt_q <= '0;
					if (den_q == '0) begin
						res_st_q <= ST_DIV0;
						state_q  <= S_WB;
					end else if (prod_q[2*DATA_W-1:DATA_W] >= den_q) begin
						res_st_q <= ST_OVF;
						state_q  <= S_WB;
					end else begin
						res_st_q <= ST_OK;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						state_q <= S_WB;
				end
				S_WB: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: prod_q holds the product, then its low half becomes the quotient
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					mcand_q <= req.multiplicand;
					den_q   <= req.denominator;
					prod_q  <= {{DATA_W{1'b0}}, req.multiplier};
				end
			end
			S_MUL: begin
				prod_q <= {mul_sum, prod_q[DATA_W-1:1]};
			end
			S_CHK: begin
				rem_q <= prod_q[2*DATA_W-1:DATA_W];
			end
			S_DIV: begin
				rem_q  <= div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
				prod_q <= {prod_q[2*DATA_W-1:DATA_W], prod_q[DATA_W-2:0], div_ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_WB && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WB && out_free) begin
			out_st_q   <= res_st_q;
			out_quot_q <= (res_st_q == ST_OK) ? prod_q[DATA_W-1:0] : {DATA_W{1'b1}};
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.quotient = out_quot_q;
	assign rsp.status   = out_st_q;

	`MDS_ASSERT_NOW(a_sat_all_ones, rsp.valid && rsp.status != ST_OK, rsp.quotient == {DATA_W{1'b1}}, "saturated result is not all ones")
	`MDS_ASSERT_NOW(a_status_code, rsp.valid, rsp.status == ST_OK || rsp.status == ST_OVF || rsp.status == ST_DIV0, "undefined status code")
	`MDS_ASSERT_NOW(a_rem_below_den, state_q == S_DIV, rem_q < den_q, "partial remainder not below divisor")
	`MDS_ASSERT_NEXT(a_take_starts_mul, req.valid && req.ready, state_q == S_MUL && !req.ready, "transfer did not start the multiply")

endmodule

/* bench/tb_mul_div_64_saturating.sv */
`timescale 1ns / 1ps

module tb_mul_div_64_saturating;
	import mds_pkg::*;

	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned DRAIN_CYCLES = 150;
	localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};

	typedef struct packed {
		logic [DATA_W-1:0] quotient;
		status_t           status;
	} muldiv_result_t;

	logic clk;
	logic arst_n;

	mds_req_if req_ch ();
	mds_rsp_if rsp_ch ();

	mul_div_64_saturating uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	muldiv_result_t quotients_due[$];
	int unsigned    err_count;
	int unsigned    idle_cycles;
	int unsigned    ready_hold;
	bit             no_idle;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(a*b/d) over the full 128-bit product, saturating
	function automatic muldiv_result_t predict_muldiv(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [DATA_W-1:0] d);
		logic [2*DATA_W-1:0] prod;
		logic [2*DATA_W-1:0] quo;
		muldiv_result_t      res;
		prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
		if (d == '0) begin
			res.quotient = ONES;
			res.status   = ST_DIV0;
		end else if (prod[2*DATA_W-1:DATA_W] >= d) begin
			res.quotient = ONES;
			res.status   = ST_OVF;
		end else begin
			quo          = prod / {{DATA_W{1'b0}}, d};
			res.quotient = quo[DATA_W-1:0];
			res.status   = ST_OK;
		end
		return res;
	endfunction

	function automatic int unsigned pick_gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 94)
			return $urandom_range(4, 25);
		return $urandom_range(60, 200);
	endfunction

	function automatic logic [DATA_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// random value of random bit length
	function automatic logic [DATA_W-1:0] rand_sized();
		return rand64() >> $urandom_range(0, DATA_W - 1);
	endfunction

	function automatic logic [DATA_W-1:0] upper_of(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [2*DATA_W-1:0] prod;
		prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
		return prod[2*DATA_W-1:DATA_W];
	endfunction

	// transfer tracking, result checking and the stall watchdog
	always @(posedge clk) begin
		muldiv_result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				quotients_due.push_back(predict_muldiv(req_ch.multiplicand,
					req_ch.multiplier, req_ch.denominator));
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (quotients_due.size() == 0) begin
					$error("result with nothing outstanding: quotient %h status %0d",
						rsp_ch.quotient, rsp_ch.status);
					err_count++;
				end else begin
					want = quotients_due.pop_front();
					if (rsp_ch.quotient !== want.quotient) begin
						$error("quotient: expected %h, got %h", want.quotient,
							rsp_ch.quotient);
						err_count++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status,
							rsp_ch.status);
						err_count++;
					end
				end
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_mul_div_64_saturating: errors");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		if (no_idle) begin
			rsp_ch.ready <= 1'b1;
			ready_hold   <= 0;
		end else if (ready_hold != 0)
			ready_hold <= ready_hold - 1;
		else if ($urandom_range(0, 99) < 65) begin
			rsp_ch.ready <= 1'b1;
			ready_hold   <= $urandom_range(0, 30);
		end else begin
			rsp_ch.ready <= 1'b0;
			ready_hold   <= pick_gap_len();
		end
	end

	task automatic send_item(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
			logic [DATA_W-1:0] d);
		int unsigned gap;
		gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap_len();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.multiplicand <= a;
		req_ch.multiplier   <= b;
		req_ch.denominator  <= d;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic test_zero_denominator();
		send_item('0, '0, '0);
		send_item(ONES, ONES, '0);
		send_item(64'h0000_0001_0000_0000, 64'h5, '0);
	endtask

	task automatic test_overflow_edges();
		send_item(64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000, 64'd1); // upper == d
		send_item(64'h8000_0000_0000_0000, 64'd4, 64'd2);                   // upper == d
		send_item(64'h8000_0000_0000_0000, 64'd4, 64'd3);                   // upper just below
		send_item(64'h8000_0000_0000_0000, 64'd2, 64'd2);
		send_item(ONES, ONES, 64'd2);
		send_item(ONES, ONES, 64'h8000_0000_0000_0000);
		send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
			64'h4000_0000_0000_0001);
	endtask

	task automatic test_extremes();
		send_item('0, '0, 64'd1);
		send_item(ONES, ONES, ONES);     // remainder carries out of the top bit
		send_item(ONES, 64'd1, 64'd1);
		send_item(64'd1, ONES, ONES);
		send_item(ONES, '0, 64'd1);
		send_item(ONES, 64'h8000_0000_0000_0005, ONES - 64'd1);
		send_item(64'd12345, 64'd67890, 64'd7);
	endtask

	task automatic random_item();
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] d;
		logic [DATA_W-1:0] hi;
		int unsigned       pick;
		pick = $urandom_range(0, 99);
		a    = rand_sized();
		b    = rand_sized();
		hi   = upper_of(a, b);
		if (pick < 60) begin
			// denominator above the upper half, so the divider runs
			d = rand64();
			if (hi != ONES && d <= hi)
				d = hi + 64'd1 + (d % ~hi);
		end else if (pick < 75) begin
			a = rand64();
			b = rand64();
			d = rand64();
		end else if (pick < 85) begin
			case ($urandom_range(0, 2))
				0: d = hi;
				1: d = hi + 64'd1;
				default: d = hi - $urandom_range(0, 3);
			endcase
		end else if (pick < 93) begin
			d = '0;
		end else begin
			case ($urandom_range(0, 3))
				0: a = '0;
				1: b = ONES;
				2: a = 64'd1;
				default: b = 64'h8000_0000_0000_0000;
			endcase
			d = rand_sized();
		end
		send_item(a, b, d);
	endtask

	task automatic test_random_mix(int unsigned count);
		repeat (count) random_item();
	endtask

	task automatic test_back_to_back(int unsigned count);
		no_idle = 1'b1;
		repeat (count) random_item();
		no_idle = 1'b0;
	endtask

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.multiplicand = '0;
		req_ch.multiplier   = '0;
		req_ch.denominator  = '0;
		rsp_ch.ready        = 1'b0;
		err_count           = 0;
		idle_cycles         = 0;
		ready_hold          = 0;
		no_idle             = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_denominator();
		test_overflow_edges();
		test_extremes();
		test_random_mix(800);
		test_back_to_back(120);
		test_random_mix(810);

		req_ch.valid <= 1'b0;
		while (quotients_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (quotients_due.size() != 0) begin
			$error("%0d results never arrived", quotients_due.size());
			err_count++;
		end
		if (err_count == 0)
			$display("tb_mul_div_64_saturating: clean");
		else
			$display("tb_mul_div_64_saturating: errors");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/mds_pkg.sv
rtl/core/mds_if.sv
rtl/core/mul_div_64_saturating.sv
bench/tb_mul_div_64_saturating.sv
